// ===== rtl/sts_pkg.sv =====
// shared types and constants for the section timing statistics block
`default_nettype none
package sts_pkg;
    localparam int MAX_SECTIONS = 16;
    localparam int RING_DEPTH   = 60;
    localparam logic [31:0] THROTTLE_RESET = 32'd2000;
    localparam logic [31:0] WINDOW_RESET   = 32'd60000;
    localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;

    localparam logic [2:0] OP_REGISTER = 3'd0;
    localparam logic [2:0] OP_START    = 3'd1;
    localparam logic [2:0] OP_STOP     = 3'd2;
    localparam logic [2:0] OP_READ     = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_NOSEC   = 3'd1;
    localparam logic [2:0] ST_NESTED  = 3'd2;
    localparam logic [2:0] ST_NOSTART = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam logic [0:0] REG_THROTTLE = 1'd0;
    localparam logic [0:0] REG_WINDOW   = 1'd1;

    // commands from controller to datapath
    typedef struct packed {
        logic latch;     // capture input beat
        logic exec;      // perform the operation on the tables
        logic scan_clr;  // reset ring scan counter
        logic scan_step; // examine one ring entry
        logic ring_clr;  // clear one ring entry
        logic finish;    // load result register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic is_read;
        logic is_clear;
        logic scan_last;
    } t_stat;
endpackage
`default_nettype wire

// ===== rtl/sts_ctrl.sv =====
// controller state machine for the section timing statistics block
`default_nettype none
module sts_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire sts_pkg::t_stat i_stat,
    output sts_pkg::t_cmd      o_cmd
);
    typedef enum logic [2:0] {S_INIT, S_IDLE, S_EXEC, S_SCAN, S_WIPE, S_DONE} t_state;
    t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid;
        o_cmd = '0;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        case (r_state)
            S_INIT: begin
                // ring wiped once after reset
                o_cmd.ring_clr = 1'b1;
                if (i_stat.scan_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.scan_clr = 1'b1;
                if (i_stat.is_read) n_state = S_SCAN;
                else if (i_stat.is_clear) n_state = S_WIPE;
                else begin
                    o_cmd.exec = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    o_cmd.exec = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_WIPE: begin
                o_cmd.ring_clr = 1'b1;
                if (i_stat.scan_last) begin
                    o_cmd.exec = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/sts_dp.sv =====
// datapath: section tables, warning ring and statistics arithmetic
`default_nettype none
module sts_dp #(
    parameter int MAX_SECTIONS = sts_pkg::MAX_SECTIONS,
    parameter int RING_DEPTH   = sts_pkg::RING_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sts_pkg::t_cmd i_cmd,
    output sts_pkg::t_stat     o_stat,
    input  wire logic [31:0]   i_throttle_ms,
    input  wire logic [31:0]   i_window_ms,
    input  wire logic [2:0]    i_operation,
    input  wire logic [3:0]    i_section,
    input  wire logic [31:0]   i_threshold_us,
    input  wire logic [31:0]   i_time_us,
    input  wire logic [31:0]   i_time_ms,
    output logic [2:0]         o_status,
    output logic [3:0]         o_sect_id,
    output logic [31:0]        o_elapsed_us,
    output logic [31:0]        o_calls,
    output logic [31:0]        o_total_us,
    output logic [31:0]        o_min_us,
    output logic [31:0]        o_max_us,
    output logic [31:0]        o_last_us,
    output logic [31:0]        o_warn_total,
    output logic               o_over_threshold,
    output logic [5:0]         o_recent_warns
);
    localparam int SW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CW = $clog2(MAX_SECTIONS + 1);
    localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int NW = $clog2(RING_DEPTH + 1);

    // latched input beat
    logic [2:0]  r_op;
    logic [3:0]  r_sec;
    logic [31:0] r_thr, r_tus, r_tms;

    logic [CW-1:0] r_used;
    logic          r_run   [MAX_SECTIONS];
    logic [31:0]   r_start [MAX_SECTIONS];
    logic [31:0]   r_cnt   [MAX_SECTIONS];
    logic [31:0]   r_tot   [MAX_SECTIONS];
    logic [31:0]   r_min   [MAX_SECTIONS];
    logic [31:0]   r_max   [MAX_SECTIONS];
    logic [31:0]   r_last  [MAX_SECTIONS];
    logic [31:0]   r_warn  [MAX_SECTIONS];
    logic [31:0]   r_lim   [MAX_SECTIONS];
    logic [31:0]   r_wstamp[MAX_SECTIONS];

    logic [RW-1:0] r_ptr, r_scan;
    logic [NW-1:0] r_n, n_tally;
    logic [RW-1:0] ring_addr;
    logic          ring_we;
    logic [31:0]   ring_wd, ring_rd;
    logic          r_rd_ok;
    logic          hit;

    // state seen by the operation, kept for the result
    logic          r_was_run, r_was_full, r_over;
    logic [31:0]   r_el;

    logic [2:0]    n_status;
    logic [3:0]    n_sect;
    logic [31:0]   n_elapsed, n_calls, n_total, n_min, n_max, n_last, n_warns;
    logic          n_over;
    logic [5:0]    n_recent;

    logic          valid, full;
    logic [SW-1:0] sidx, uidx;
    logic [31:0]   el, age;
    logic          over, rec;

    assign full  = (r_used >= CW'(MAX_SECTIONS));
    assign valid = (32'(r_sec) < 32'(r_used)) && (32'(r_sec) < 32'(MAX_SECTIONS));
    assign sidx  = SW'(r_sec);
    assign uidx  = SW'(r_used);
    assign el    = r_tus - r_start[sidx];
    assign over  = (r_lim[sidx] != 32'd0) && (el > r_lim[sidx]);
    assign rec   = over && ((r_tms - r_wstamp[sidx]) > i_throttle_ms);
    assign age   = r_tms - ring_rd;
    assign hit   = r_rd_ok && (ring_rd != 32'd0) && (age < i_window_ms);
    assign n_tally = r_n + NW'(hit);

    assign o_stat.is_read   = (r_op == sts_pkg::OP_READ) && valid;
    assign o_stat.is_clear  = (r_op == sts_pkg::OP_CLEAR);
    assign o_stat.scan_last = (r_scan == RW'(RING_DEPTH - 1));

    // ring port: scan read, wipe, or warning record
    always_comb begin
        ring_addr = r_scan;
        ring_we = 1'b0;
        ring_wd = 32'd0;
        if (i_cmd.ring_clr) begin
            ring_we = 1'b1;
        end else if (i_cmd.exec && r_op == sts_pkg::OP_STOP && valid && r_run[sidx] && rec) begin
            ring_we = 1'b1;
            ring_addr = r_ptr;
            ring_wd = r_tms;
        end
    end

    sts_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_ring (
        .i_clk(i_clk), .i_we(ring_we), .i_addr(ring_addr), .i_wdata(ring_wd),
        .o_rdata(ring_rd)
    );

    // control state and ring counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_ptr <= '0;
            r_scan <= '0;
            r_n <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_rd_ok <= i_cmd.scan_step;
            if (i_cmd.scan_clr) begin
                r_scan <= '0;
            end else if (i_cmd.scan_step || i_cmd.ring_clr) begin
                if (!o_stat.scan_last) r_scan <= r_scan + RW'(1);
            end
            // entry read last cycle is tallied here
            if (i_cmd.scan_clr) r_n <= '0;
            else if (hit) r_n <= n_tally;
            if (i_cmd.exec) begin
                if (r_op == sts_pkg::OP_REGISTER && !full) r_used <= r_used + CW'(1);
                if (r_op == sts_pkg::OP_CLEAR) r_ptr <= '0;
                else if (ring_we) begin
                    r_ptr <= (r_ptr == RW'(RING_DEPTH - 1)) ? '0 : r_ptr + RW'(1);
                end
            end
        end
    end

    // result fields for the finished operation
    always_comb begin
        n_status = sts_pkg::ST_DONE;
        n_sect = r_sec;
        n_elapsed = '0;
        n_calls = '0;
        n_total = '0;
        n_min = '0;
        n_max = '0;
        n_last = '0;
        n_warns = '0;
        n_over = 1'b0;
        n_recent = '0;
        if (r_op == sts_pkg::OP_REGISTER) begin
            if (r_was_full) n_status = sts_pkg::ST_FULL;
            else begin
                n_sect = 4'(r_used - CW'(1));
                n_min = sts_pkg::ALL_ONES;
            end
        end else if (r_op > sts_pkg::OP_CLEAR || (!valid && r_op != sts_pkg::OP_CLEAR)) begin
            n_status = sts_pkg::ST_NOSEC;
        end else if (valid) begin
            n_calls = r_cnt[sidx];
            n_total = r_tot[sidx];
            n_min = r_min[sidx];
            n_max = r_max[sidx];
            n_last = r_last[sidx];
            n_warns = r_warn[sidx];
            if (r_op == sts_pkg::OP_START && r_was_run) n_status = sts_pkg::ST_NESTED;
            if (r_op == sts_pkg::OP_STOP) begin
                if (!r_was_run) n_status = sts_pkg::ST_NOSTART;
                else begin
                    n_elapsed = r_el;
                    n_over = r_over;
                end
            end
            if (r_op == sts_pkg::OP_READ) begin
                n_recent = (32'(n_tally) > 32'd63) ? 6'd63 : 6'(n_tally);
            end
        end
    end

    // input latch, tables and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op <= i_operation;
            r_sec <= i_section;
            r_thr <= i_threshold_us;
            r_tus <= i_time_us;
            r_tms <= i_time_ms;
        end
        if (i_cmd.exec) begin
            r_was_run <= r_run[sidx];
            r_was_full <= full;
            r_el <= el;
            r_over <= over;
            case (r_op)
                sts_pkg::OP_REGISTER: begin
                    if (!full) begin
                        r_cnt[uidx] <= '0; r_tot[uidx] <= '0; r_min[uidx] <= sts_pkg::ALL_ONES;
                        r_max[uidx] <= '0; r_last[uidx] <= '0; r_warn[uidx] <= '0;
                        r_lim[uidx] <= r_thr; r_wstamp[uidx] <= '0;
                        r_run[uidx] <= 1'b0; r_start[uidx] <= '0;
                    end
                end
                sts_pkg::OP_START: begin
                    if (valid && !r_run[sidx]) begin
                        r_run[sidx] <= 1'b1;
                        r_start[sidx] <= r_tus;
                    end
                end
                sts_pkg::OP_STOP: begin
                    if (valid && r_run[sidx]) begin
                        r_cnt[sidx] <= r_cnt[sidx] + 32'd1;
                        r_tot[sidx] <= r_tot[sidx] + el;
                        r_last[sidx] <= el;
                        if (el < r_min[sidx]) r_min[sidx] <= el;
                        if (el > r_max[sidx]) r_max[sidx] <= el;
                        if (over) r_warn[sidx] <= r_warn[sidx] + 32'd1;
                        if (rec) r_wstamp[sidx] <= r_tms;
                        r_run[sidx] <= 1'b0;
                    end
                end
                sts_pkg::OP_CLEAR: begin
                    for (int k = 0; k < MAX_SECTIONS; k++) begin
                        if (k < 32'(r_used)) begin
                            r_cnt[k] <= '0; r_tot[k] <= '0; r_min[k] <= sts_pkg::ALL_ONES;
                            r_max[k] <= '0; r_last[k] <= '0; r_warn[k] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.finish) begin
            o_status <= n_status;
            o_sect_id <= n_sect;
            o_elapsed_us <= n_elapsed;
            o_calls <= n_calls;
            o_total_us <= n_total;
            o_min_us <= n_min;
            o_max_us <= n_max;
            o_last_us <= n_last;
            o_warn_total <= n_warns;
            o_over_threshold <= n_over;
            o_recent_warns <= n_recent;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/sts_ram.sv =====
// generic single-port ram with registered read
`default_nettype none
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 60
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/section_timing_statistics.sv =====
// top level: section timing statistics monitor, one beat in flight at a time
// register, start, stop, unknown codes, unregistered reads: EXEC, then DONE registers the result
// read of a registered section and clear walk the ring one entry per cycle
// in SCAN or WIPE between EXEC and DONE, and DONE registers the result
// synchronous active-low reset clears section count, ring pointer and handshake state,
// then wipes every ring entry in S_INIT while the input is held not ready
`default_nettype none
module section_timing_statistics #(
    parameter int MAX_SECTIONS = sts_pkg::MAX_SECTIONS,
    parameter int RING_DEPTH   = sts_pkg::RING_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_operation,
    input  wire logic [3:0]  i_section,
    input  wire logic [31:0] i_threshold_us,
    input  wire logic [31:0] i_time_us,
    input  wire logic [31:0] i_time_ms,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [3:0]       o_sect_id,
    output logic [31:0]      o_elapsed_us,
    output logic [31:0]      o_calls,
    output logic [31:0]      o_total_us,
    output logic [31:0]      o_min_us,
    output logic [31:0]      o_max_us,
    output logic [31:0]      o_last_us,
    output logic [31:0]      o_warn_total,
    output logic             o_over_threshold,
    output logic [5:0]       o_recent_warns,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    sts_pkg::t_cmd  cmd;
    sts_pkg::t_stat stat;
    logic [31:0] r_throttle, r_window;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sts_pkg::REG_WINDOW) ? r_window : r_throttle;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_throttle <= sts_pkg::THROTTLE_RESET;
            r_window <= sts_pkg::WINDOW_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == sts_pkg::REG_THROTTLE) r_throttle <= pwdata;
            else r_window <= pwdata;
        end
    end

    sts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_valid), .o_in_ready(o_ready),
        .o_out_valid(o_valid), .i_out_ready(i_ready), .i_stat(stat), .o_cmd(cmd)
    );

    sts_dp #(.MAX_SECTIONS(MAX_SECTIONS), .RING_DEPTH(RING_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_throttle_ms(r_throttle), .i_window_ms(r_window),
        .i_operation(i_operation), .i_section(i_section), .i_threshold_us(i_threshold_us),
        .i_time_us(i_time_us), .i_time_ms(i_time_ms),
        .o_status(o_status), .o_sect_id(o_sect_id), .o_elapsed_us(o_elapsed_us),
        .o_calls(o_calls), .o_total_us(o_total_us), .o_min_us(o_min_us),
        .o_max_us(o_max_us), .o_last_us(o_last_us), .o_warn_total(o_warn_total),
        .o_over_threshold(o_over_threshold), .o_recent_warns(o_recent_warns)
    );
endmodule
`default_nettype wire
